>>> hw/rtl/gfs_pkg.sv
// Shared types and constants of the gamepad frame sequencer.
`timescale 1ns / 1ps

package gfs_pkg;

  // Controller command codes.
  typedef enum logic [3:0] {
    CMD_PRESS   = 4'd0,
    CMD_HOLD    = 4'd1,
    CMD_RELEASE = 4'd2,
    CMD_TOGGLE  = 4'd3,
    CMD_SPAM    = 4'd4,
    CMD_IDLE    = 4'd5,
    CMD_FRAME   = 4'd6,
    CMD_LSTICK  = 4'd7,
    CMD_RSTICK  = 4'd8
  } cmd_e;

  // Button bits that are reported as triggers instead of buttons.
  localparam logic [15:0] LT_BIT    = 16'h0400;
  localparam logic [15:0] RT_BIT    = 16'h0800;
  localparam logic [15:0] BTN_KEEP  = 16'hf3ff;
  localparam logic [7:0]  TRIG_FULL = 8'd255;
  localparam logic [7:0]  TRIG_OFF  = 8'd0;

  // One command as it sits in the input stage.
  typedef struct packed {
    logic [3:0]         command;
    logic [3:0]         button;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
  } cmd_t;

  // One gamepad report frame.
  typedef struct packed {
    logic [15:0]        buttons;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
  } report_t;

endpackage

>>> hw/rtl/gfs_state.sv
// Button masks, stick registers and report formation of the frame sequencer.
`timescale 1ns / 1ps

module gfs_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             exec_i,
  input  gfs_pkg::cmd_t    cmd_i,
  output gfs_pkg::report_t report_o
);

  logic [15:0]        press_q, press_d;
  logic [15:0]        hold_q, hold_d;
  logic [15:0]        front_q, front_d;
  logic [15:0]        back_q, back_d;
  logic signed [15:0] lx_q, lx_d, ly_q, ly_d;
  logic signed [15:0] rx_q, rx_d, ry_q, ry_d;
  logic [15:0]        bit_sel;
  logic [15:0]        all_btn;

  assign bit_sel = 16'd1 << cmd_i.button;

  // Command decoder: next value of every mask and stick register.
  always_comb begin
    press_d = press_q;
    hold_d  = hold_q;
    front_d = front_q;
    back_d  = back_q;
    lx_d    = lx_q;
    ly_d    = ly_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    if (exec_i) begin
      unique case (cmd_i.command)
        gfs_pkg::CMD_PRESS:  press_d = press_q | bit_sel;
        gfs_pkg::CMD_HOLD:   hold_d  = hold_q | bit_sel;
        gfs_pkg::CMD_TOGGLE: hold_d  = hold_q ^ bit_sel;
        gfs_pkg::CMD_SPAM:   front_d = front_q | bit_sel;
        gfs_pkg::CMD_RELEASE: begin
          hold_d  = hold_q & ~bit_sel;
          front_d = front_q & ~bit_sel;
          back_d  = back_q & ~bit_sel;
        end
        gfs_pkg::CMD_IDLE: begin
          press_d = '0;
          hold_d  = '0;
          front_d = '0;
          back_d  = '0;
          lx_d    = '0;
          ly_d    = '0;
          rx_d    = '0;
          ry_d    = '0;
        end
        gfs_pkg::CMD_FRAME: begin
          press_d = '0;
          front_d = back_q;
          back_d  = front_q;
        end
        gfs_pkg::CMD_LSTICK: begin
          lx_d = cmd_i.stick_x;
          ly_d = cmd_i.stick_y;
        end
        gfs_pkg::CMD_RSTICK: begin
          rx_d = cmd_i.stick_x;
          ry_d = cmd_i.stick_y;
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_q <= '0;
      hold_q  <= '0;
      front_q <= '0;
      back_q  <= '0;
      lx_q    <= '0;
      ly_q    <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
    end else begin
      press_q <= press_d;
      hold_q  <= hold_d;
      front_q <= front_d;
      back_q  <= back_d;
      lx_q    <= lx_d;
      ly_q    <= ly_d;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
    end
  end

  // Report built from the current state, before the frame updates it.
  assign all_btn = press_q | hold_q | front_q;

  always_comb begin
    report_o.buttons       = all_btn & gfs_pkg::BTN_KEEP;
    report_o.left_trigger  = |(all_btn & gfs_pkg::LT_BIT) ? gfs_pkg::TRIG_FULL
                                                          : gfs_pkg::TRIG_OFF;
    report_o.right_trigger = |(all_btn & gfs_pkg::RT_BIT) ? gfs_pkg::TRIG_FULL
                                                          : gfs_pkg::TRIG_OFF;
    report_o.left_x        = lx_q;
    report_o.left_y        = ly_q;
    report_o.right_x       = rx_q;
    report_o.right_y       = ry_q;
  end

endmodule

>>> hw/rtl/gamepad_frame_sequencer_unit.sv
// Top level of the gamepad frame sequencer: input stage, state and report register.
`timescale 1ns / 1ps

// Takes one controller command per clock cycle and emits one report frame
// for each frame command. A command is registered in the input stage on
// transfer and applied from there to the button masks and stick registers;
// a frame command loads the report register as it is applied, so a report
// passes the input stage and the report register before it shows on the output.
// Throughput is one command per cycle; the only
// stall is a frame command meeting a report register that still holds an
// untaken report, which holds the input stage until the report is taken.
// Sticks are stored unchanged as signed Q1.15; button bits 10 and 11 leave the
// report as full-scale trigger values.
module gamepad_frame_sequencer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         command_i,
  input  logic [3:0]         button_i,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        buttons_o,
  output logic [7:0]         left_trigger_o,
  output logic [7:0]         right_trigger_o,
  output logic signed [15:0] left_x_o,
  output logic signed [15:0] left_y_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] right_y_o
);

  logic             in_valid_q;
  gfs_pkg::cmd_t    cmd_q;
  logic             out_valid_q;
  gfs_pkg::report_t rep_q;
  gfs_pkg::report_t rep_now;
  logic             out_free;
  logic             is_frame;
  logic             exec;

  // Stage control: a frame command needs room in the report register.
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_frame   = (cmd_q.command == gfs_pkg::CMD_FRAME);
  assign exec       = in_valid_q && (!is_frame || out_free);
  assign in_ready_o = !in_valid_q || exec;

  // Input stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input stage payload, loaded on every transfer.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q.command <= command_i;
      cmd_q.button  <= button_i;
      cmd_q.stick_x <= stick_x_i;
      cmd_q.stick_y <= stick_y_i;
    end
  end

  gfs_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (exec),
    .cmd_i    (cmd_q),
    .report_o (rep_now)
  );

  // Report register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec && is_frame) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Report register payload.
  always_ff @(posedge clk_i) begin
    if (exec && is_frame) begin
      rep_q <= rep_now;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign buttons_o       = rep_q.buttons;
  assign left_trigger_o  = rep_q.left_trigger;
  assign right_trigger_o = rep_q.right_trigger;
  assign left_x_o        = rep_q.left_x;
  assign left_y_o        = rep_q.left_y;
  assign right_x_o       = rep_q.right_x;
  assign right_y_o       = rep_q.right_y;

  // A frame command never overwrites a report that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && is_frame && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("frame command advanced over an untaken report");

  // A stalled command stays in the input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !exec) |=> (in_valid_q && $stable(cmd_q)))
    else $error("stalled command lost from the input stage");

  // Trigger bits never appear in the reported button mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((buttons_o & ~gfs_pkg::BTN_KEEP) == 16'd0))
    else $error("trigger bits leaked into the button mask");

  // Triggers are either fully off or fully on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((left_trigger_o == gfs_pkg::TRIG_OFF ||
                      left_trigger_o == gfs_pkg::TRIG_FULL) &&
                     (right_trigger_o == gfs_pkg::TRIG_OFF ||
                      right_trigger_o == gfs_pkg::TRIG_FULL)))
    else $error("trigger value is neither off nor full scale");

endmodule

>>> bench/gamepad_frame_sequencer_unit_test.sv
// Self-checking testbench for the gamepad frame sequencer: predicted reports vs. the DUT output.
`timescale 1ns / 1ps

module gamepad_frame_sequencer_unit_test;

  localparam logic [3:0] LAST_CODE   = 4'd15;
  localparam int         RANDOM_CMDS = 1850;
  localparam int         CALM_TAIL   = 150;
  localparam int         STALL_LIMIT = 1000;
  localparam int         DRAIN_WAIT  = 8;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_ready_o;
  logic [3:0]         command_i       = '0;
  logic [3:0]         button_i        = '0;
  logic signed [15:0] stick_x_i       = '0;
  logic signed [15:0] stick_y_i       = '0;
  logic               out_valid_o;
  logic               out_ready       = 1'b0;
  logic [15:0]        buttons_o;
  logic [7:0]         left_trigger_o;
  logic [7:0]         right_trigger_o;
  logic signed [15:0] left_x_o;
  logic signed [15:0] left_y_o;
  logic signed [15:0] right_x_o;
  logic signed [15:0] right_y_o;

  gamepad_frame_sequencer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .button_i        (button_i),
    .stick_x_i       (stick_x_i),
    .stick_y_i       (stick_y_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .buttons_o       (buttons_o),
    .left_trigger_o  (left_trigger_o),
    .right_trigger_o (right_trigger_o),
    .left_x_o        (left_x_o),
    .left_y_o        (left_y_o),
    .right_x_o       (right_x_o),
    .right_y_o       (right_y_o)
  );

  // Commands waiting to be driven, and reports waiting to come out.
  gfs_pkg::cmd_t    cmds_pending[$];
  gfs_pkg::report_t reports_due[$];

  // Predicted controller state.
  logic [15:0]        press_bits  = '0;
  logic [15:0]        hold_bits   = '0;
  logic [15:0]        turbo_now   = '0;
  logic [15:0]        turbo_next  = '0;
  logic signed [15:0] lstick_x    = '0;
  logic signed [15:0] lstick_y    = '0;
  logic signed [15:0] rstick_x    = '0;
  logic signed [15:0] rstick_y    = '0;

  int    errors        = 0;
  int    cmds_taken    = 0;
  int    frames_seen   = 0;
  int    stall_cycles  = 0;
  logic  in_took       = 1'b0;
  int    in_gap        = 0;
  int    out_gap       = 0;
  logic  in_quiet      = 1'b0;
  logic  out_quiet     = 1'b0;
  gfs_pkg::cmd_t next_cmd;

  // Clock generator.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic queue_cmd(input logic [3:0] code, input logic [3:0] btn,
                           input logic signed [15:0] sx, input logic signed [15:0] sy);
    gfs_pkg::cmd_t c;
    c.command = code;
    c.button  = btn;
    c.stick_x = sx;
    c.stick_y = sy;
    cmds_pending.push_back(c);
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return -16'sd1;
      default: return 16'($urandom);
    endcase
  endfunction

  // Applies one accepted command to the predicted state; a frame queues its report.
  task automatic sequence_command(input gfs_pkg::cmd_t c);
    logic [15:0]      bit_sel;
    logic [15:0]      active;
    logic [15:0]      swap;
    gfs_pkg::report_t rep;
    bit_sel = 16'h0001 << c.button;
    case (c.command)
      gfs_pkg::CMD_PRESS:   press_bits = press_bits | bit_sel;
      gfs_pkg::CMD_HOLD:    hold_bits  = hold_bits | bit_sel;
      gfs_pkg::CMD_TOGGLE:  hold_bits  = hold_bits ^ bit_sel;
      gfs_pkg::CMD_SPAM:    turbo_now  = turbo_now | bit_sel;
      gfs_pkg::CMD_RELEASE: begin
        hold_bits  = hold_bits & ~bit_sel;
        turbo_now  = turbo_now & ~bit_sel;
        turbo_next = turbo_next & ~bit_sel;
      end
      gfs_pkg::CMD_IDLE: begin
        press_bits = '0;
        hold_bits  = '0;
        turbo_now  = '0;
        turbo_next = '0;
        lstick_x   = '0;
        lstick_y   = '0;
        rstick_x   = '0;
        rstick_y   = '0;
      end
      gfs_pkg::CMD_FRAME: begin
        active            = press_bits | hold_bits | turbo_now;
        rep.buttons       = active & gfs_pkg::BTN_KEEP;
        rep.left_trigger  = (active & gfs_pkg::LT_BIT) != '0 ? gfs_pkg::TRIG_FULL
                                                            : gfs_pkg::TRIG_OFF;
        rep.right_trigger = (active & gfs_pkg::RT_BIT) != '0 ? gfs_pkg::TRIG_FULL
                                                            : gfs_pkg::TRIG_OFF;
        rep.left_x        = lstick_x;
        rep.left_y        = lstick_y;
        rep.right_x       = rstick_x;
        rep.right_y       = rstick_y;
        reports_due.push_back(rep);
        press_bits = '0;
        swap       = turbo_now;
        turbo_now  = turbo_next;
        turbo_next = swap;
      end
      gfs_pkg::CMD_LSTICK: begin
        lstick_x = c.stick_x;
        lstick_y = c.stick_y;
      end
      gfs_pkg::CMD_RSTICK: begin
        rstick_x = c.stick_x;
        rstick_y = c.stick_y;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compares one report transfer with the oldest prediction.
  task automatic check_report();
    gfs_pkg::report_t want;
    if (reports_due.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected report, expected none, actual buttons %h", $time,
               buttons_o);
    end else begin
      want = reports_due.pop_front();
      frames_seen++;
      check_field("buttons", want.buttons, buttons_o);
      check_field("left_trigger", {8'h00, want.left_trigger}, {8'h00, left_trigger_o});
      check_field("right_trigger", {8'h00, want.right_trigger}, {8'h00, right_trigger_o});
      check_field("left_x", want.left_x, left_x_o);
      check_field("left_y", want.left_y, left_y_o);
      check_field("right_x", want.right_x, right_x_o);
      check_field("right_y", want.right_y, right_y_o);
    end
  endtask

  // Command driver: at the falling edge after the last transfer, a new command goes out unless an idle gap is inserted.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!in_quiet && cmds_pending.size() >= CALM_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        in_gap   <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (cmds_pending.size() > 0) begin
        next_cmd = cmds_pending.pop_front();
        command_i <= next_cmd.command;
        button_i  <= next_cmd.button;
        stick_x_i <= next_cmd.stick_x;
        stick_y_i <= next_cmd.stick_y;
        in_valid  <= 1'b1;
        if ($urandom_range(0, 39) == 0) begin
          in_quiet <= 1'($urandom_range(0, 1));
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Report receiver back-pressure.
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (rst_ni && !out_quiet && cmds_pending.size() >= CALM_TAIL &&
                 $urandom_range(0, 5) == 0) begin
      out_gap   <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 39) == 0) begin
        out_quiet <= 1'($urandom_range(0, 1));
      end
    end
  end

  // Monitor: checks reports, predicts from accepted commands, and watches for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took <= in_valid && in_ready_o;
      if (out_valid_o && out_ready) begin
        check_report();
      end
      if (in_valid && in_ready_o) begin
        cmds_taken++;
        sequence_command('{command_i, button_i, stick_x_i, stick_y_i});
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int          useful;
    int          runs;
    logic [3:0]  btn;
    int unsigned pick;

    // Directed opening: empty frame, trigger bits, turbo alternation, release, toggles, sticks, unused codes, idle.
    queue_cmd(gfs_pkg::CMD_FRAME, 4'd0, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_PRESS, 4'd0, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_HOLD, 4'd15, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_SPAM, 4'd10, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_FRAME, 4'd0, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_FRAME, 4'd0, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_FRAME, 4'd0, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_PRESS, 4'd11, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_RELEASE, 4'd10, 16'sh0000, 16'sh0000);
    // Release of a pressed bit leaves the press pending.
    queue_cmd(gfs_pkg::CMD_RELEASE, 4'd11, 16'sh1234, 16'sh5678);
    queue_cmd(gfs_pkg::CMD_FRAME, 4'd0, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_TOGGLE, 4'd15, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_TOGGLE, 4'd3, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_LSTICK, 4'd7, 16'sh8000, 16'sh7fff);
    queue_cmd(gfs_pkg::CMD_RSTICK, 4'd0, 16'sh7fff, 16'sh8000);
    // Unused command codes must be ignored.
    queue_cmd(gfs_pkg::CMD_RSTICK + 4'd1, 4'd5, 16'sh4321, 16'sh1111);
    queue_cmd(LAST_CODE, 4'd15, -16'sd1, -16'sd1);
    queue_cmd(gfs_pkg::CMD_FRAME, 4'd15, 16'sh7777, 16'sh8888);
    queue_cmd(gfs_pkg::CMD_IDLE, 4'd9, 16'sh2222, 16'sh3333);
    queue_cmd(gfs_pkg::CMD_FRAME, 4'd0, 16'sh0000, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_LSTICK, 4'd0, -16'sd1, 16'sh0000);
    queue_cmd(gfs_pkg::CMD_RSTICK, 4'd0, 16'sh0000, -16'sd1);
    queue_cmd(gfs_pkg::CMD_FRAME, 4'd0, 16'sh0000, 16'sh0000);

    // Random part: weighted commands, with turbo runs spread through.
    useful = 0;
    while (useful < RANDOM_CMDS) begin
      pick = $urandom_range(0, 99);
      btn  = 4'($urandom_range(0, 15));
      if (pick < 3) begin
        queue_cmd(4'($urandom_range(gfs_pkg::CMD_RSTICK + 1, LAST_CODE)), btn,
                  16'($urandom), 16'($urandom));
      end else if (pick < 9) begin
        runs = $urandom_range(2, 6);
        queue_cmd(gfs_pkg::CMD_SPAM, btn, 16'($urandom), 16'($urandom));
        repeat (runs) begin
          queue_cmd(gfs_pkg::CMD_FRAME, 4'($urandom), 16'($urandom), 16'($urandom));
        end
        if ($urandom_range(0, 1) == 0) begin
          queue_cmd(gfs_pkg::CMD_RELEASE, btn, 16'($urandom), 16'($urandom));
          useful++;
        end
        useful += runs + 1;
      end else begin
        if (pick < 34) begin
          queue_cmd(gfs_pkg::CMD_FRAME, btn, 16'($urandom), 16'($urandom));
        end else if (pick < 44) begin
          queue_cmd(gfs_pkg::CMD_PRESS, btn, 16'($urandom), 16'($urandom));
        end else if (pick < 54) begin
          queue_cmd(gfs_pkg::CMD_HOLD, btn, 16'($urandom), 16'($urandom));
        end else if (pick < 63) begin
          queue_cmd(gfs_pkg::CMD_RELEASE, btn, 16'($urandom), 16'($urandom));
        end else if (pick < 72) begin
          queue_cmd(gfs_pkg::CMD_TOGGLE, btn, 16'($urandom), 16'($urandom));
        end else if (pick < 81) begin
          queue_cmd(gfs_pkg::CMD_SPAM, btn, 16'($urandom), 16'($urandom));
        end else if (pick < 84) begin
          queue_cmd(gfs_pkg::CMD_IDLE, btn, 16'($urandom), 16'($urandom));
        end else if (pick < 92) begin
          queue_cmd(gfs_pkg::CMD_LSTICK, btn, pick_axis(), pick_axis());
        end else begin
          queue_cmd(gfs_pkg::CMD_RSTICK, btn, pick_axis(), pick_axis());
        end
        useful++;
      end
    end

    // Reset held low at the start, released on a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every command to go in and every report to come out.
    while (cmds_pending.size() != 0 || in_valid || reports_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run covered %0d accepted commands and %0d checked report frames.",
             cmds_taken, frames_seen);
    $display("Mismatches found: %0d.", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
